// ===== design/pdc_pkg.sv =====
package pdc_pkg;

    // Default sizes of the point store
    localparam int PDC_NUM_POINTS = 256;
    localparam int PDC_NUM_DIMS   = 8;

    // Fixed field widths
    localparam int COORD_W = 32;
    localparam int K_W     = 4;

    // k after reset
    localparam logic [K_W-1:0] K_RESET = 4'd8;

    // Queue depths between the parts
    localparam int CMD_Q_DEPTH = 4;
    localparam int RSP_Q_DEPTH = 2;

    // Request type codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [7:0]         point_index;
        logic [2:0]         dim_index;
        logic signed [31:0] coord_value;
        logic [7:0]         other_index;
    } req_t;

    typedef struct packed {
        logic p_dominates_q;
        logic q_dominates_p;
        logic p_kdominates_q;
        logic q_kdominates_p;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } back_state_t;

endpackage

// ===== design/pdc_fifo.sv =====
module pdc_fifo import pdc_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers with wrap at the queue depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed word
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

// ===== design/pdc_front.sv =====
module pdc_front import pdc_pkg::*;
#(
    parameter int NUM_POINTS = PDC_NUM_POINTS,
    parameter int NUM_DIMS   = PDC_NUM_DIMS,
    parameter int ADDR_W     = $clog2(PDC_NUM_POINTS * PDC_NUM_DIMS)
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               push,
    input  req_t                               req,
    output logic                               full,
    input  logic                               cmd_full,
    output logic                               cmd_push,
    output logic [1 + 2*ADDR_W + COORD_W - 1:0] cmd_data
);

    localparam int PT_W  = $clog2(NUM_POINTS);
    localparam int CMD_W = 1 + 2*ADDR_W + COORD_W;

    // Reduce an 8-bit index modulo the point count by shifted subtraction
    function automatic logic [7:0] wrap_point(input logic [7:0] idx);
        logic [8:0] v;
        v = {1'b0, idx};
        for (int i = 7; i >= 0; i--)
        begin
            if (((32'(NUM_POINTS) << i) <= 32'd255) && (32'(v) >= (32'(NUM_POINTS) << i)))
            begin
                v = v - 9'(32'(NUM_POINTS) << i);
            end
        end
        return v[7:0];
    endfunction

    logic [PT_W-1:0]   pt_p;
    logic [PT_W-1:0]   pt_q;
    logic [ADDR_W-1:0] base_p;
    logic [ADDR_W-1:0] base_q;
    logic [ADDR_W-1:0] load_addr;
    logic              is_query;
    logic              keep;
    logic              accept;
    logic [CMD_W-1:0]  cmd_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic              cmd_vld_reg;

    // Classify the word and form store addresses
    always_comb
    begin
        pt_p      = PT_W'(wrap_point(req.point_index));
        pt_q      = PT_W'(wrap_point(req.other_index));
        base_p    = ADDR_W'(pt_p) * ADDR_W'(NUM_DIMS);
        base_q    = ADDR_W'(pt_q) * ADDR_W'(NUM_DIMS);
        load_addr = base_p + ADDR_W'(req.dim_index);
        is_query  = (req.req_type == REQ_QUERY);
        keep      = is_query || (32'(req.dim_index) < 32'(NUM_DIMS));
        cmd_next  = {is_query, (is_query ? base_p : load_addr), base_q, req.coord_value};
    end

    assign full     = cmd_vld_reg && cmd_full;
    assign accept   = push && !full;
    assign cmd_push = cmd_vld_reg && !cmd_full;
    assign cmd_data = cmd_reg;

    // Hold the classified word until the queue takes it; drop loads past the last dimension
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
        end
        else if (accept && keep)
        begin
            cmd_vld_reg <= 1'b1;
        end
        else if (cmd_push)
        begin
            cmd_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

// ===== design/pdc_back.sv =====
module pdc_back import pdc_pkg::*;
#(
    parameter int NUM_POINTS = PDC_NUM_POINTS,
    parameter int NUM_DIMS   = PDC_NUM_DIMS,
    parameter int ADDR_W     = $clog2(PDC_NUM_POINTS * PDC_NUM_DIMS)
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_empty,
    input  logic [1 + 2*ADDR_W + COORD_W - 1:0] cmd_data,
    output logic                               cmd_pop,
    input  logic [K_W-1:0]                     k_required,
    input  logic                               rsp_full,
    output logic                               rsp_push,
    output rsp_t                               rsp_data
);

    localparam int CMD_W     = 1 + 2*ADDR_W + COORD_W;
    localparam int MEM_DEPTH = NUM_POINTS * NUM_DIMS;
    localparam int CNT_W     = $clog2(NUM_DIMS + 1);
    localparam int CMP_W     = (CNT_W > K_W) ? CNT_W : K_W;

    logic                      cmd_query;
    logic [ADDR_W-1:0]         cmd_addr_a;
    logic [ADDR_W-1:0]         cmd_addr_b;
    logic signed [COORD_W-1:0] cmd_coord;

    back_state_t               state_reg, state_next;
    logic [ADDR_W-1:0]         base_a_reg, base_b_reg;
    logic [CNT_W-1:0]          dim_reg, dim_next;
    logic                      start;
    logic                      mem_we;
    logic                      rd_en;
    logic                      rd_vld_reg;
    logic [ADDR_W-1:0]         rd_addr_a;
    logic [ADDR_W-1:0]         rd_addr_b;
    logic signed [COORD_W-1:0] rd_a_reg, rd_b_reg;
    logic signed [COORD_W-1:0] store_mem [MEM_DEPTH];
    logic [CNT_W-1:0]          p_ge_reg, p_gt_reg, q_ge_reg, q_gt_reg;

    // Unpack the queued word
    assign cmd_query  = cmd_data[CMD_W-1];
    assign cmd_addr_a = cmd_data[CMD_W-2 -: ADDR_W];
    assign cmd_addr_b = cmd_data[CMD_W-2-ADDR_W -: ADDR_W];
    assign cmd_coord  = cmd_data[COORD_W-1:0];

    assign rd_addr_a = base_a_reg + ADDR_W'(dim_reg);
    assign rd_addr_b = base_b_reg + ADDR_W'(dim_reg);

    // Sequence loads and dimension scans
    always_comb
    begin
        state_next = state_reg;
        dim_next   = dim_reg;
        cmd_pop    = 1'b0;
        mem_we     = 1'b0;
        rd_en      = 1'b0;
        start      = 1'b0;
        rsp_push   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    if (cmd_query)
                    begin
                        start      = 1'b1;
                        dim_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                rd_en    = 1'b1;
                dim_next = dim_reg + 1'b1;
                if (dim_reg == CNT_W'(NUM_DIMS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_full)
                begin
                    rsp_push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            dim_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            dim_reg    <= dim_next;
            rd_vld_reg <= rd_en;
        end
    end

    // Latch the two point bases at query start
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            base_a_reg <= cmd_addr_a;
            base_b_reg <= cmd_addr_b;
        end
    end

    // Point store: one write port, two registered read ports
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store_mem[cmd_addr_a] <= cmd_coord;
        end
        if (rd_en)
        begin
            rd_a_reg <= store_mem[rd_addr_a];
            rd_b_reg <= store_mem[rd_addr_b];
        end
    end

    // Count dimensions not smaller and strictly larger, both directions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_ge_reg <= '0;
            p_gt_reg <= '0;
            q_ge_reg <= '0;
            q_gt_reg <= '0;
        end
        else if (start)
        begin
            p_ge_reg <= '0;
            p_gt_reg <= '0;
            q_ge_reg <= '0;
            q_gt_reg <= '0;
        end
        else if (rd_vld_reg)
        begin
            p_ge_reg <= p_ge_reg + CNT_W'(rd_a_reg >= rd_b_reg);
            p_gt_reg <= p_gt_reg + CNT_W'(rd_a_reg > rd_b_reg);
            q_ge_reg <= q_ge_reg + CNT_W'(rd_b_reg >= rd_a_reg);
            q_gt_reg <= q_gt_reg + CNT_W'(rd_b_reg > rd_a_reg);
        end
    end

    // Form the four flags from the counts
    always_comb
    begin
        rsp_data.p_dominates_q  = (p_ge_reg == CNT_W'(NUM_DIMS)) && (p_gt_reg != '0);
        rsp_data.q_dominates_p  = (q_ge_reg == CNT_W'(NUM_DIMS)) && (q_gt_reg != '0);
        rsp_data.p_kdominates_q = (k_required != '0) && (p_gt_reg != '0)
                                  && (CMP_W'(p_ge_reg) >= CMP_W'(k_required));
        rsp_data.q_kdominates_p = (k_required != '0) && (q_gt_reg != '0)
                                  && (CMP_W'(q_ge_reg) >= CMP_W'(k_required));
    end

`ifndef SYNTHESIS
    a_read_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        rd_vld_reg |-> ($past(state_reg) == ST_SCAN))
        else $error("read data valid without a scan cycle");
    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_push |-> !rsp_full)
        else $error("result pushed into a full queue");
    a_counts_cover_dims: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |->
        ((CNT_W+1)'(p_ge_reg) + (CNT_W+1)'(q_gt_reg) == (CNT_W+1)'(NUM_DIMS)))
        else $error("comparison counts do not cover every dimension");
`endif

endmodule

// ===== design/point_dominance_checker_core.sv =====
// Point dominance checker.
// Input side is a queue: drive req and raise push; the word is taken at a clock
// edge where push is high and full is low. A load writes one coordinate of one
// point; loads to a dimension past the last are taken and dropped. A query names
// points p and q and returns one result word with full and k-dominance flags in
// both directions.
// Result side is a queue: while empty is low, rsp holds the oldest result; raise
// pop to take it. A stalled receiver fills the result queue, the back end then
// holds its finished result, the command queue fills, and finally full rises.
// The k register is written over cfg_valid/cfg_data (cfg_ready is always high);
// write it only while the block is idle.
// The back end takes one command at a time: a load writes the point store from
// its idle state; a query scans one dimension of both points per cycle from the
// two-read-port point store, then drains and pushes its result once the result
// queue has room, and only then takes the next command.
// Reset clears control state and sets k to 8; the point store is not cleared.
module point_dominance_checker_core import pdc_pkg::*;
#(
    parameter int NUM_POINTS = PDC_NUM_POINTS,
    parameter int NUM_DIMS   = PDC_NUM_DIMS
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  req_t           req,
    output logic           full,
    output logic           empty,
    input  logic           pop,
    output rsp_t           rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [K_W-1:0] cfg_data
);

    localparam int ADDR_W = $clog2(NUM_POINTS * NUM_DIMS);
    localparam int CMD_W  = 1 + 2*ADDR_W + COORD_W;
    localparam int RSP_W  = $bits(rsp_t);

    logic [K_W-1:0]   k_reg;
    logic             fq_push;
    logic [CMD_W-1:0] fq_data;
    logic             fq_full;
    logic             bq_pop;
    logic [CMD_W-1:0] bq_data;
    logic             bq_empty;
    logic             rsp_push;
    rsp_t             rsp_word;
    logic             rsp_full;
    logic [RSP_W-1:0] rsp_bits;

    // Hold the k register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg <= K_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            k_reg <= cfg_data;
        end
    end

    pdc_front #(
        .NUM_POINTS (NUM_POINTS),
        .NUM_DIMS   (NUM_DIMS),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .req      (req),
        .full     (full),
        .cmd_full (fq_full),
        .cmd_push (fq_push),
        .cmd_data (fq_data)
    );

    pdc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_Q_DEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fq_push),
        .wr_data (fq_data),
        .full    (fq_full),
        .pop     (bq_pop),
        .rd_data (bq_data),
        .empty   (bq_empty)
    );

    pdc_back #(
        .NUM_POINTS (NUM_POINTS),
        .NUM_DIMS   (NUM_DIMS),
        .ADDR_W     (ADDR_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (bq_empty),
        .cmd_data   (bq_data),
        .cmd_pop    (bq_pop),
        .k_required (k_reg),
        .rsp_full   (rsp_full),
        .rsp_push   (rsp_push),
        .rsp_data   (rsp_word)
    );

    pdc_fifo #(
        .WIDTH (RSP_W),
        .DEPTH (RSP_Q_DEPTH)
    ) u_rsp_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (rsp_push),
        .wr_data (rsp_word),
        .full    (rsp_full),
        .pop     (pop),
        .rd_data (rsp_bits),
        .empty   (empty)
    );

    assign rsp = rsp_bits;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pdc_pkg::*;

    localparam int NPTS         = PDC_NUM_POINTS;
    localparam int NDIMS        = PDC_NUM_DIMS;
    localparam int DRAIN_CYCLES = 40;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 55;
    localparam int NUM_PHASES   = 8;
    localparam int MAX_PRINTED  = 50;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFFFFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh80000000;

    // Trend of a generated point against the point it is derived from
    typedef enum int { TREND_UP, TREND_DOWN, TREND_MIXED } trend_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           push      = 1'b0;
    req_t           req       = '0;
    logic           full;
    logic           empty;
    logic           pop       = 1'b0;
    rsp_t           rsp;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [K_W-1:0] cfg_data  = '0;

    point_dominance_checker_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .req       (req),
        .full      (full),
        .empty     (empty),
        .pop       (pop),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Predictor state: point store and k as the block should hold them
    logic signed [COORD_W-1:0] coord_mem [NPTS][NDIMS];
    logic [K_W-1:0]            k_model = K_RESET;

    // Generator view of the store, used to keep queries on loaded points
    logic signed [COORD_W-1:0] gen_coord [NPTS][NDIMS];
    logic [NDIMS-1:0]          gen_mask  [NPTS];
    int                        complete_pts [$];

    req_t req_backlog    [$];
    rsp_t expected_flags [$];

    int  n_errors      = 0;
    int  n_queued      = 0;
    int  n_loads       = 0;
    int  n_queries     = 0;
    int  n_results     = 0;
    int  n_cfg_writes  = 0;
    int  flag_hits [4] = '{0, 0, 0, 0};
    int  stall_cycles  = 0;
    bit  no_idle       = 1'b0;

    int  gap_left      = 0;
    int  pop_hold_left = 0;
    bit  word_taken;

    initial begin
        forever #5 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        if (n_errors < MAX_PRINTED)
            $display("ERROR @%0t: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic string flag_name(input int b);
        case (b)
            3:       return "p_dominates_q";
            2:       return "q_dominates_p";
            1:       return "p_kdominates_q";
            default: return "q_kdominates_p";
        endcase
    endfunction

    // Compute the four dominance flags of p over q and q over p
    function automatic rsp_t dominance_flags(input int p, input int q);
        int   p_ge;
        int   p_gt;
        int   q_ge;
        int   q_gt;
        rsp_t f;
        p_ge = 0;
        p_gt = 0;
        q_ge = 0;
        q_gt = 0;
        for (int d = 0; d < NDIMS; d++)
        begin
            if (coord_mem[p][d] >= coord_mem[q][d]) p_ge++;
            if (coord_mem[p][d] >  coord_mem[q][d]) p_gt++;
            if (coord_mem[q][d] >= coord_mem[p][d]) q_ge++;
            if (coord_mem[q][d] >  coord_mem[p][d]) q_gt++;
        end
        f.p_dominates_q  = (p_ge == NDIMS) && (p_gt != 0);
        f.q_dominates_p  = (q_ge == NDIMS) && (q_gt != 0);
        // k of zero or above the dimension count never holds
        f.p_kdominates_q = (k_model != 0) && (p_gt != 0) && (p_ge >= int'(k_model));
        f.q_kdominates_p = (k_model != 0) && (q_gt != 0) && (q_ge >= int'(k_model));
        return f;
    endfunction

    // Update the store on a load, or queue the flags a query must return
    task automatic apply_request(input req_t r);
        if (r.req_type == REQ_LOAD)
        begin
            if (int'(r.dim_index) < NDIMS)
                coord_mem[r.point_index][r.dim_index] = r.coord_value;
            n_loads++;
        end
        else
        begin
            expected_flags.insert(expected_flags.size(),
                dominance_flags(r.point_index, r.other_index));
            n_queries++;
        end
    endtask

    task automatic queue_load(input int p, input int d, input logic signed [COORD_W-1:0] v);
        req_t r;
        r.req_type    = REQ_LOAD;
        r.point_index = p[7:0];
        r.dim_index   = d[2:0];
        r.coord_value = v;
        // fill the ignored field with noise
        r.other_index = 8'($urandom);
        req_backlog.insert(req_backlog.size(), r);
        gen_coord[p][d] = v;
        if (gen_mask[p] != '1)
        begin
            gen_mask[p][d] = 1'b1;
            if (gen_mask[p] == '1)
                complete_pts.insert(complete_pts.size(), p);
        end
        n_queued++;
    endtask

    task automatic queue_query(input int p, input int q);
        req_t r;
        r.req_type    = REQ_QUERY;
        r.point_index = p[7:0];
        r.other_index = q[7:0];
        r.dim_index   = 3'($urandom);
        r.coord_value = $urandom;
        req_backlog.insert(req_backlog.size(), r);
        n_queued++;
    endtask

    // Pick a coordinate near base, following the trend, with some extremes
    function automatic logic signed [COORD_W-1:0] pick_coord(
        input logic signed [COORD_W-1:0] base, input trend_t trend);
        int sel;
        sel = $urandom_range(0, 15);
        case (sel)
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return $urandom;
            default:
            begin
                case (trend)
                    TREND_UP:   return base + $urandom_range(0, 1);
                    TREND_DOWN: return base - $urandom_range(0, 1);
                    default:    return base + $urandom_range(0, 2) - 1;
                endcase
            end
        endcase
    endfunction

    // Load all dimensions of one point, mostly derived from a loaded point
    task automatic queue_whole_point();
        int     p;
        int     b;
        trend_t trend;
        logic signed [COORD_W-1:0] base;
        p     = $urandom_range(0, NPTS - 1);
        b     = (complete_pts.size() != 0) ?
                complete_pts[$urandom_range(0, complete_pts.size() - 1)] : -1;
        trend = trend_t'($urandom_range(0, 2));
        for (int d = 0; d < NDIMS; d++)
        begin
            base = (b >= 0) ? gen_coord[b][d] : $signed($urandom_range(0, 6)) - 3;
            queue_load(p, d, pick_coord(base, trend));
        end
    endtask

    task automatic queue_random_phase(input int count);
        int start;
        int sel;
        int p;
        int q;
        int d;
        start = n_queued;
        while (n_queued - start < count)
        begin
            sel = $urandom_range(0, 9);
            if (complete_pts.size() < 2 || sel < 2)
                queue_whole_point();
            else if (sel < 4)
            begin
                d = $urandom_range(0, NDIMS - 1);
                // scattered load to any point, or a tweak of a loaded one
                if ($urandom_range(0, 2) == 0)
                    queue_load($urandom_range(0, NPTS - 1), d, $urandom);
                else
                begin
                    p = complete_pts[$urandom_range(0, complete_pts.size() - 1)];
                    queue_load(p, d, pick_coord(gen_coord[p][d], TREND_MIXED));
                end
            end
            else
            begin
                p = complete_pts[$urandom_range(0, complete_pts.size() - 1)];
                if ($urandom_range(0, 15) == 0)
                    q = p;
                else
                    q = complete_pts[$urandom_range(0, complete_pts.size() - 1)];
                queue_query(p, q);
            end
        end
    endtask

    // Write k; call right after a rising edge
    task automatic write_k(input logic [K_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        k_model = v;
        n_cfg_writes++;
        cfg_valid <= 1'b0;
    endtask

    // Wait for all words to be taken and all results back, then let loads settle
    task automatic wait_idle();
        do
            @(posedge clk);
        while (req_backlog.size() != 0 || expected_flags.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Driver: offer the oldest pending word, with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push     <= 1'b0;
            req      <= '0;
            gap_left  = 0;
        end
        else
        begin
            word_taken = push && !full;
            if (word_taken)
            begin
                apply_request(req);
                void'(req_backlog.pop_front());
            end
            // hold a word that was not taken
            if (push && !word_taken)
                ;
            else if (gap_left > 0)
            begin
                gap_left--;
                push <= 1'b0;
            end
            else if (req_backlog.size() == 0)
                push <= 1'b0;
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                gap_left = $urandom_range(0, 9);
                push <= 1'b0;
            end
            else
            begin
                push <= 1'b1;
                req  <= req_backlog[0];
            end
        end
    end

    // Monitor: take results with random stalls and check each flag
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop           <= 1'b0;
            pop_hold_left  = 0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_flags.size() == 0)
                    flag_error($sformatf("result word %b with none expected", rsp));
                else
                begin
                    for (int b = 3; b >= 0; b--)
                    begin
                        if (rsp[b] !== expected_flags[0][b])
                            flag_error($sformatf("result %0d: %s expected %b got %b",
                                n_results, flag_name(b), expected_flags[0][b], rsp[b]));
                    end
                    void'(expected_flags.pop_front());
                end
                for (int b = 0; b < 4; b++)
                    if (rsp[b] === 1'b1) flag_hits[b]++;
                n_results++;
            end
            if (pop_hold_left > 0)
            begin
                pop_hold_left--;
                pop <= 1'b0;
            end
            else if (!no_idle && $urandom_range(0, 7) == 0)
            begin
                pop_hold_left = $urandom_range(0, 9);
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    // Count cycles in which no word moves on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        logic [K_W-1:0] k_plan [NUM_PHASES];
        foreach (gen_mask[i])
            gen_mask[i] = '0;
        k_plan = '{4'd1, 4'd0, 4'd15, 4'd4, 4'd9, 4'd0, 4'd2, 4'd8};
        k_plan[5] = K_W'($urandom_range(1, NDIMS));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extreme points, self query, one dimension then made equal
        for (int d = 0; d < NDIMS; d++)
            queue_load(0, d, COORD_MAX);
        for (int d = 0; d < NDIMS; d++)
            queue_load(NPTS - 1, d, COORD_MIN);
        queue_query(0, NPTS - 1);
        queue_query(NPTS - 1, 0);
        queue_query(0, 0);
        queue_load(NPTS - 1, 5, COORD_MAX);
        queue_query(0, NPTS - 1);
        queue_query(NPTS - 1, 0);
        wait_idle();

        // Random phases, each with its own k; last phase runs without idling
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_k(k_plan[ph]);
            no_idle = (ph == NUM_PHASES - 1);
            queue_random_phase(PHASE_ITEMS);
            wait_idle();
        end

        if (expected_flags.size() != 0)
            flag_error($sformatf("%0d results never arrived", expected_flags.size()));

        $display("Covered %0d loads and %0d queries over %0d k settings, %0d results checked",
            n_loads, n_queries, n_cfg_writes, n_results);
        $display("Flags set: p_dom %0d, q_dom %0d, p_kdom %0d, q_kdom %0d; %0d mismatches",
            flag_hits[3], flag_hits[2], flag_hits[1], flag_hits[0], n_errors);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
design/pdc_pkg.sv
design/pdc_fifo.sv
design/pdc_front.sv
design/pdc_back.sv
design/point_dominance_checker_core.sv
tb/sv/tb.sv
